// File: rtl/zlm_pkg.sv
// ----------------------------------------------------------------------------
// Zone liveness monitor package
// Shared constants, codes and types for the zone table and the walk unit.
// ----------------------------------------------------------------------------
package zlm_pkg;

  localparam int ZONES   = 64;
  localparam int ZIDX_W  = $clog2(ZONES);
  localparam int CNT_W   = 6;
  localparam int TOT_W   = 22;
  localparam int USERS_W = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int NUM_W   = 17;

  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [TOT_W-1:0]  TOTAL_MAX = '1;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [ZIDX_W-1:0] LAST_ZONE = ZIDX_W'(ZONES - 1);

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_QUERY   = 2'd2
  } zlm_cmd_t;

  typedef enum logic [1:0] {
    CFG_DEAD_TIMEOUT   = 2'd0,
    CFG_SCAN_INTERVAL  = 2'd1,
    CFG_BALANCE_ENABLE = 2'd2
  } zlm_cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  last_seen;
    logic [USERS_W-1:0] users;
  } zlm_entry_t;

  typedef struct packed {
    logic              clear;
    logic              en;
    logic              scan;
    logic              alive;
    logic [ZIDX_W-1:0] idx;
  } zlm_eval_ctl_t;

  typedef struct packed {
    logic              kill;
    logic [CNT_W-1:0]  cnt;
    logic [TOT_W-1:0]  total;
    logic [ZIDX_W-1:0] lowest;
  } zlm_eval_res_t;

endpackage

// File: rtl/zlm_zone_ram.sv
// ----------------------------------------------------------------------------
// Zone table memory
// One write port and one registered read port holding stamp and user count.
// ----------------------------------------------------------------------------
module zlm_zone_ram
  import zlm_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ZIDX_W-1:0] waddr,
  input  zlm_entry_t        wdata,
  input  logic [ZIDX_W-1:0] raddr,
  output zlm_entry_t        rdata
);

  zlm_entry_t mem [ZONES];
  zlm_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/zlm_eval_unit.sv
// ----------------------------------------------------------------------------
// Zone walk unit
// Evaluates one table entry per cycle: expiry, active count, online total
// and least-loaded zone.
// ----------------------------------------------------------------------------
module zlm_eval_unit
  import zlm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  zlm_eval_ctl_t     ctl,
  input  zlm_entry_t        entry,
  input  logic [TIME_W-1:0] now,
  input  logic [CFG_W-1:0]  timeout,
  output zlm_eval_res_t     res
);

  logic [CNT_W-1:0]   cnt_r;
  logic [TOT_W-1:0]   total_r;
  logic [ZIDX_W-1:0]  best_r;
  logic [USERS_W-1:0] best_users_r;
  logic               found_r;

  logic [TIME_W:0]    deadline;
  logic               dead;
  logic               alive_after;
  logic [TOT_W:0]     sum;
  logic [TOT_W-1:0]   total_nxt;

  assign deadline    = {1'b0, entry.last_seen} + (TIME_W+1)'(timeout);
  assign dead        = {1'b0, now} > deadline;
  assign alive_after = ctl.alive & ~(ctl.scan & dead);
  assign sum         = {1'b0, total_r} + (TOT_W+1)'(entry.users);
  assign total_nxt   = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      cnt_r        <= '0;
      total_r      <= '0;
      best_r       <= '0;
      best_users_r <= '0;
      found_r      <= 1'b0;
    end else if (ctl.en && alive_after) begin
      if (cnt_r != CNT_MAX) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      total_r <= total_nxt;
      if (!found_r || entry.users <= best_users_r) begin
        best_r       <= ctl.idx;
        best_users_r <= entry.users;
        found_r      <= 1'b1;
      end
    end
  end

  assign res.kill   = ctl.en & ctl.scan & ctl.alive & dead;
  assign res.cnt    = cnt_r;
  assign res.total  = total_r;
  assign res.lowest = best_r;

endmodule

// File: rtl/zone_liveness_monitor.sv
// ----------------------------------------------------------------------------
// Zone liveness monitor
// Heartbeat table with timed liveness scans and least-loaded zone search.
// ----------------------------------------------------------------------------
// Each word keeps busy high through DECIDE, ZONE (valid query or refresh only),
// BAL1 to BAL3 (refresh with balancing only), PASS, DRAIN and DONE; the result
// strobe out_valid comes in the first cycle after busy falls and lasts one cycle,
// with no hold-off: take the result word then. The busy time is set by the walk
// over the zone table through its single read port, one entry per cycle, which
// every word performs to find the least-loaded zone and, on a due tick, to expire
// stale zones.
// ----------------------------------------------------------------------------
module zone_liveness_monitor
  import zlm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_command,
  input  logic [5:0]             in_zone_id,
  input  logic signed [NUM_W-1:0] in_online_number,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output logic                   out_valid,
  output logic                   out_scan_done,
  output logic                   out_zone_rejected,
  output logic                   out_kick_zone,
  output logic                   out_zone_active,
  output logic [USERS_W-1:0]     out_zone_online,
  output logic                   out_zone_busy,
  output logic [CNT_W-1:0]       out_active_zones,
  output logic [TOT_W-1:0]       out_world_online,
  output logic [5:0]             out_lowest_zone
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECIDE = 9'b000000010,
    ST_ZONE   = 9'b000000100,
    ST_BAL1   = 9'b000001000,
    ST_BAL2   = 9'b000010000,
    ST_BAL3   = 9'b000100000,
    ST_PASS   = 9'b001000000,
    ST_DRAIN  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]        dead_timeout_r;
  logic [CFG_W-1:0]        scan_interval_r;
  logic                    balance_enable_r;

  logic [ZONES-1:0]        alive_r;
  logic [ZONES-1:0]        busy_state_r;
  logic [TIME_W-1:0]       now_r;
  logic [TIME_W-1:0]       last_scan_r;
  logic [CNT_W-1:0]        alive_count_r;
  logic [TOT_W-1:0]        online_total_r;

  zlm_cmd_t                cmd_r;
  logic [ZIDX_W-1:0]       zid_r;
  logic signed [NUM_W-1:0] num_r;
  logic                    rej_r;
  logic                    scan_r;
  logic                    res_kick_r;
  logic                    res_act_r;
  logic [USERS_W-1:0]      res_onl_r;
  logic                    res_busy_r;
  logic [USERS_W-1:0]      u1_r;

  logic [ZIDX_W-1:0]       pass_addr_r;
  logic                    eval_en_r;
  logic [ZIDX_W-1:0]       eval_idx_r;

  logic                    out_valid_r;
  logic                    out_scan_done_r;
  logic                    out_zone_rejected_r;
  logic                    out_kick_zone_r;
  logic                    out_zone_active_r;
  logic [USERS_W-1:0]      out_zone_online_r;
  logic                    out_zone_busy_r;
  logic [CNT_W-1:0]        out_active_zones_r;
  logic [TOT_W-1:0]        out_world_online_r;
  logic [ZIDX_W-1:0]       out_lowest_zone_r;

  logic                    ram_we;
  logic [ZIDX_W-1:0]       ram_raddr;
  zlm_entry_t              ram_wdata;
  zlm_entry_t              ram_rdata;

  zlm_eval_ctl_t           eval_ctl;
  zlm_eval_res_t           eval_res;

  logic                    accept;
  logic                    in_rej;
  logic                    kick_w;
  logic [USERS_W-1:0]      old_users;
  logic [USERS_W-1:0]      new_users;
  logic [USERS_W-1:0]      u2;
  logic                    hot1;
  logic [TIME_W:0]         scan_due;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign in_rej    = (in_zone_id == 6'd0) || (int'(in_zone_id) >= ZONES);
  assign kick_w    = (num_r == -NUM_W'(1));
  assign old_users = alive_r[zid_r] ? ram_rdata.users : '0;
  assign new_users = kick_w   ? '0 :
                     num_r[NUM_W-1] ? old_users : num_r[USERS_W-1:0];
  assign u2        = alive_r[2] ? ram_rdata.users : '0;
  assign hot1      = (u1_r > u2);
  assign scan_due  = {1'b0, last_scan_r} + (TIME_W+1)'(scan_interval_r);

  assign ram_we              = (state_r == ST_ZONE) && (cmd_r == CMD_REFRESH);
  assign ram_wdata.last_seen = now_r;
  assign ram_wdata.users     = new_users;

  always_comb begin
    case (state_r)
      ST_BAL1: ram_raddr = ZIDX_W'(1);
      ST_BAL2: ram_raddr = ZIDX_W'(2);
      ST_PASS: ram_raddr = pass_addr_r;
      default: ram_raddr = zid_r;
    endcase
  end

  zlm_zone_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (zid_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign eval_ctl.clear = (state_r == ST_DECIDE);
  assign eval_ctl.en    = eval_en_r;
  assign eval_ctl.scan  = scan_r;
  assign eval_ctl.alive = alive_r[eval_idx_r];
  assign eval_ctl.idx   = eval_idx_r;

  zlm_eval_unit u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (eval_ctl),
    .entry   (ram_rdata),
    .now     (now_r),
    .timeout (dead_timeout_r),
    .res     (eval_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if ((cmd_r == CMD_REFRESH || cmd_r == CMD_QUERY) && !rej_r) begin
          state_nxt = ST_ZONE;
        end else begin
          state_nxt = ST_PASS;
        end
      end
      ST_ZONE: begin
        if (cmd_r == CMD_REFRESH && balance_enable_r) begin
          state_nxt = ST_BAL1;
        end else begin
          state_nxt = ST_PASS;
        end
      end
      ST_BAL1:   state_nxt = ST_BAL2;
      ST_BAL2:   state_nxt = ST_BAL3;
      ST_BAL3:   state_nxt = ST_PASS;
      ST_PASS:   if (pass_addr_r == LAST_ZONE) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      dead_timeout_r   <= CFG_W'(60);
      scan_interval_r  <= CFG_W'(1);
      balance_enable_r <= 1'b0;
      alive_r          <= '0;
      busy_state_r     <= '0;
      now_r            <= '0;
      last_scan_r      <= '0;
      alive_count_r    <= '0;
      online_total_r   <= '0;
      eval_en_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      eval_en_r   <= (state_r == ST_PASS);
      eval_idx_r  <= pass_addr_r;

      if (cfg_we) begin
        case (cfg_index)
          CFG_DEAD_TIMEOUT:   dead_timeout_r   <= cfg_wdata;
          CFG_SCAN_INTERVAL:  scan_interval_r  <= cfg_wdata;
          CFG_BALANCE_ENABLE: balance_enable_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (eval_res.kill) begin
        alive_r[eval_idx_r] <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r      <= zlm_cmd_t'(in_command);
            zid_r      <= ZIDX_W'(in_zone_id);
            num_r      <= in_online_number;
            rej_r      <= in_rej && (in_command == CMD_REFRESH ||
                                     in_command == CMD_QUERY);
            scan_r     <= 1'b0;
            res_kick_r <= 1'b0;
            res_act_r  <= 1'b0;
            res_onl_r  <= '0;
            res_busy_r <= 1'b0;
            if (in_command == CMD_TICK && now_r != TIME_MAX) begin
              now_r <= now_r + TIME_W'(1);
            end
          end
        end
        ST_DECIDE: begin
          pass_addr_r <= ZIDX_W'(1);
          if (cmd_r == CMD_TICK && {1'b0, now_r} >= scan_due) begin
            scan_r      <= 1'b1;
            last_scan_r <= now_r;
          end
        end
        ST_ZONE: begin
          if (cmd_r == CMD_REFRESH) begin
            alive_r[zid_r] <= 1'b1;
            if (!alive_r[zid_r] && alive_count_r != CNT_MAX) begin
              alive_count_r <= alive_count_r + CNT_W'(1);
            end
            res_act_r  <= 1'b1;
            res_onl_r  <= new_users;
            res_kick_r <= kick_w;
            if (balance_enable_r) begin
              res_busy_r <= busy_state_r[zid_r];
            end else begin
              busy_state_r[zid_r] <= 1'b0;
              res_busy_r          <= 1'b0;
            end
          end else begin
            res_act_r  <= alive_r[zid_r];
            res_onl_r  <= old_users;
            res_busy_r <= busy_state_r[zid_r];
          end
        end
        ST_BAL2: begin
          u1_r <= alive_r[1] ? ram_rdata.users : '0;
        end
        ST_BAL3: begin
          busy_state_r[1] <= hot1;
          busy_state_r[2] <= ~hot1;
          if (zid_r == ZIDX_W'(1)) begin
            res_busy_r <= hot1;
          end else if (zid_r == ZIDX_W'(2)) begin
            res_busy_r <= ~hot1;
          end
        end
        ST_PASS: begin
          pass_addr_r <= pass_addr_r + ZIDX_W'(1);
        end
        ST_DONE: begin
          if (scan_r) begin
            alive_count_r  <= eval_res.cnt;
            online_total_r <= eval_res.total;
          end
          out_valid_r         <= 1'b1;
          out_scan_done_r     <= scan_r;
          out_zone_rejected_r <= rej_r;
          out_kick_zone_r     <= res_kick_r;
          out_zone_active_r   <= res_act_r;
          out_zone_online_r   <= res_onl_r;
          out_zone_busy_r     <= res_busy_r;
          out_active_zones_r  <= scan_r ? eval_res.cnt : alive_count_r;
          out_world_online_r  <= scan_r ? eval_res.total : online_total_r;
          out_lowest_zone_r   <= eval_res.lowest;
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scan_done     = out_scan_done_r;
  assign out_zone_rejected = out_zone_rejected_r;
  assign out_kick_zone     = out_kick_zone_r;
  assign out_zone_active   = out_zone_active_r;
  assign out_zone_online   = out_zone_online_r;
  assign out_zone_busy     = out_zone_busy_r;
  assign out_active_zones  = out_active_zones_r;
  assign out_world_online  = out_world_online_r;
  assign out_lowest_zone   = 6'(out_lowest_zone_r);

  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_DONE) && !busy)
    else $error("result strobe without a finished word");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  a_kill_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    eval_res.kill |-> scan_r && (state_r == ST_PASS || state_r == ST_DRAIN))
    else $error("zone expired outside a liveness scan");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zone_rejected) |-> !out_kick_zone && !out_zone_active
      && !out_scan_done)
    else $error("rejected zone produced zone status");

endmodule
